// ===== design/tmk_pkg.sv =====
// Package for the thin multipole kick block: request types, microcode control word
// and the read-only microprogram that drives the sequencer. No dependencies.
package tmk_pkg;

  typedef struct packed {
    logic              func;
    logic [2:0]        coef_index;
    logic signed [63:0] coef_skew;
    logic signed [63:0] coef_normal;
    logic signed [63:0] pos_x;
    logic signed [63:0] mom_x;
    logic signed [63:0] pos_y;
    logic signed [63:0] mom_y;
    logic signed [63:0] kick_len;
  } in_req_t;

  typedef struct packed {
    logic signed [63:0] mom_x_out;
    logic signed [63:0] mom_y_out;
    logic               saturated;
  } out_req_t;

  // Request function codes.
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_KICK = 1'b1;

  // Result of the shared multiplier, seen by the sequencer.
  typedef struct packed {
    logic               done;
    logic               sat;
    logic signed [63:0] prod;
  } mul_res_t;

  typedef enum logic {SEQ_IDLE, SEQ_RUN} seq_state_t;

  typedef enum logic [1:0] {MA_RE, MA_IM, MA_LEN} mul_a_t;
  typedef enum logic [1:0] {MB_X, MB_Y, MB_RE, MB_IM} mul_b_t;
  typedef enum logic [1:0] {ALU_PASS, ALU_ADD, ALU_SUB} alu_op_t;
  typedef enum logic [1:0] {AA_T, AA_U, AA_PX, AA_PY} alu_a_t;
  typedef enum logic [1:0] {AB_PROD, AB_NORM, AB_SKEW} alu_b_t;
  typedef enum logic [2:0] {DST_NONE, DST_T, DST_U, DST_IM, DST_PX, DST_PY} dst_t;

  typedef logic [3:0] step_t;

  localparam step_t STEP_LOOP = 4'd0;
  localparam step_t STEP_KICK = 4'd6;
  localparam step_t STEP_END  = 4'd8;

  typedef struct packed {
    logic    use_mul;
    mul_a_t  ma;
    mul_b_t  mb;
    alu_op_t op;
    alu_a_t  aa;
    alu_b_t  ab;
    dst_t    dst;
    logic    re_load;
    logic    dec_idx;
    logic    jmp_nz;
    step_t   target;
    logic    done;
  } cw_t;

  // Microprogram. Steps 0 to 5 are one Horner iteration, 6 and 7 apply the kick,
  // step 8 hands the result to the output register.
  function automatic cw_t ucode(input step_t step);
    cw_t cw;
    cw = '{use_mul: 1'b0, ma: MA_RE, mb: MB_X, op: ALU_PASS, aa: AA_T, ab: AB_PROD,
           dst: DST_NONE, re_load: 1'b0, dec_idx: 1'b0, jmp_nz: 1'b0,
           target: STEP_LOOP, done: 1'b0};
    case (step)
      4'd0: begin
        cw.use_mul = 1'b1; cw.ma = MA_RE; cw.mb = MB_X;
        cw.op = ALU_PASS; cw.ab = AB_PROD; cw.dst = DST_T;
      end
      4'd1: begin
        cw.use_mul = 1'b1; cw.ma = MA_IM; cw.mb = MB_Y;
        cw.op = ALU_SUB; cw.aa = AA_T; cw.ab = AB_PROD; cw.dst = DST_T;
      end
      4'd2: begin
        cw.op = ALU_ADD; cw.aa = AA_T; cw.ab = AB_NORM; cw.dst = DST_T;
      end
      4'd3: begin
        cw.use_mul = 1'b1; cw.ma = MA_IM; cw.mb = MB_X;
        cw.op = ALU_PASS; cw.ab = AB_PROD; cw.dst = DST_U;
      end
      4'd4: begin
        cw.use_mul = 1'b1; cw.ma = MA_RE; cw.mb = MB_Y;
        cw.op = ALU_ADD; cw.aa = AA_U; cw.ab = AB_PROD; cw.dst = DST_U;
      end
      4'd5: begin
        cw.op = ALU_ADD; cw.aa = AA_U; cw.ab = AB_SKEW; cw.dst = DST_IM;
        cw.re_load = 1'b1; cw.dec_idx = 1'b1; cw.jmp_nz = 1'b1; cw.target = STEP_LOOP;
      end
      4'd6: begin
        cw.use_mul = 1'b1; cw.ma = MA_LEN; cw.mb = MB_RE;
        cw.op = ALU_SUB; cw.aa = AA_PX; cw.ab = AB_PROD; cw.dst = DST_PX;
      end
      4'd7: begin
        cw.use_mul = 1'b1; cw.ma = MA_LEN; cw.mb = MB_IM;
        cw.op = ALU_ADD; cw.aa = AA_PY; cw.ab = AB_PROD; cw.dst = DST_PY;
      end
      default: begin
        cw.done = 1'b1;
      end
    endcase
    return cw;
  endfunction

endpackage

// ===== design/tmk_mul.sv =====
// Shared multi-cycle Q31.32 saturating multiplier of the thin multipole kick block.
// Uses one 32x32 multiplier over four partial products. Depends on tmk_pkg.
module tmk_mul
  import tmk_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] op_a,
  input  logic signed [63:0] op_b,
  output mul_res_t           res
);

  localparam logic [2:0] CNT_PP_LAST  = 3'd3;
  localparam logic [2:0] CNT_ACC_LAST = 3'd4;
  localparam logic [2:0] CNT_LAST     = 3'd5;

  logic         busy_r;
  logic         done_r;
  logic [2:0]   cnt_r;
  logic [63:0]  ma_r;
  logic [63:0]  mb_r;
  logic         neg_r;
  logic [63:0]  pp_r;
  logic [1:0]   pp_sh_r;
  logic [127:0] acc_r;
  logic signed [63:0] prod_r;
  logic         sat_r;

  logic [31:0]  a_half;
  logic [31:0]  b_half;
  logic [63:0]  pp_nxt;
  logic [1:0]   pp_sh_nxt;
  logic [127:0] pp_shifted;
  logic [95:0]  q_w;
  logic [96:0]  c_w;
  logic         sat_w;
  logic [63:0]  fin_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 3'd1;
        end
      end
    end
  end

  // Partial product a_i * b_j carries weight 2^(32*(i+j)).
  always_comb begin
    a_half    = cnt_r[1] ? ma_r[63:32] : ma_r[31:0];
    b_half    = cnt_r[0] ? mb_r[63:32] : mb_r[31:0];
    pp_nxt    = a_half * b_half;
    pp_sh_nxt = {1'b0, cnt_r[1]} + {1'b0, cnt_r[0]};
    case (pp_sh_r)
      2'd0:    pp_shifted = {64'd0, pp_r};
      2'd1:    pp_shifted = {32'd0, pp_r, 32'd0};
      2'd2:    pp_shifted = {pp_r, 64'd0};
      default: pp_shifted = '0;
    endcase
  end

  // The signed result is floor(+-P / 2^32). For a negative sign that is -ceil(P / 2^32).
  always_comb begin
    q_w = acc_r[127:32];
    c_w = {1'b0, q_w} + {96'd0, |acc_r[31:0]};
    if (neg_r) begin
      sat_w = (|c_w[96:64]) | (c_w[63] & (|c_w[62:0]));
      fin_w = sat_w ? 64'h8000_0000_0000_0000 : (~c_w[63:0] + 64'd1);
    end else begin
      sat_w = |q_w[95:63];
      fin_w = sat_w ? 64'h7FFF_FFFF_FFFF_FFFF : q_w[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma_r  <= op_a[63] ? (~op_a + 64'd1) : op_a;
      mb_r  <= op_b[63] ? (~op_b + 64'd1) : op_b;
      neg_r <= op_a[63] ^ op_b[63];
      acc_r <= '0;
    end else if (busy_r) begin
      if (cnt_r <= CNT_PP_LAST) begin
        pp_r    <= pp_nxt;
        pp_sh_r <= pp_sh_nxt;
      end
      if (cnt_r != 3'd0 && cnt_r <= CNT_ACC_LAST) begin
        acc_r <= acc_r + pp_shifted;
      end
      if (cnt_r == CNT_LAST) begin
        prod_r <= fin_w;
        sat_r  <= sat_w;
      end
    end
  end

  assign res.done = done_r;
  assign res.sat  = sat_r;
  assign res.prod = prod_r;

endmodule

// ===== design/thin_multipole_kick_top.sv =====
// Top level of the thin multipole kick block: coefficient tables, microcoded sequencer,
// saturating adder and output register. Depends on tmk_pkg and tmk_mul.
//
// The block applies a thin-lens multipole kick to one particle per kick request.
// Requests arrive on the in_ channel (valid/ready). A load request (func 0) writes one
// skew/normal coefficient pair into the tables in the cycle it is accepted and gives
// no result. A kick request (func 1) evaluates the complex field polynomial by Horner's
// rule and returns the kicked momenta, with a sticky saturation flag, on the out_
// channel (valid/ready). The cfg_ channel writes the order in use; it is always ready
// and should be written only while the block is idle.
// A kick with order n runs n Horner iterations and is then valid in the output register:
// each Horner iteration is four products and two sums, each product runs on the single
// shared 32x32 multiplier, the kick itself needs two more products, and one last step
// loads the output register. One request is in work at a time; in_ready is high only
// while the sequencer is idle, so a kick finishes before the next request is taken,
// while a load leaves the sequencer idle. The finished result sits in the output
// register, so the next request is taken while it waits. If the receiver stalls with
// a result still held, the sequencer waits on its last step until the register
// frees up.
// Reset clears the order to 0, marks every table entry as invalid (reads as zero),
// and empties the sequencer and the output register.
module thin_multipole_kick_top
  import tmk_pkg::*;
#(
  parameter int TOP_ORDER = 7
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_req_t out_data,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic [2:0] cfg_data
);

  localparam int DEPTH = TOP_ORDER + 1;
  localparam int IDX_W = (TOP_ORDER > 0) ? $clog2(TOP_ORDER + 1) : 1;

  localparam logic signed [63:0] Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] Q_MIN = 64'sh8000_0000_0000_0000;

  // Control state.
  seq_state_t       state_r, state_nxt;
  step_t            step_r, step_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             mul_wait_r, mul_wait_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [2:0]       order_r;
  logic [DEPTH-1:0] vld_r;

  // Datapath registers.
  logic signed [63:0] x_r, x_nxt;
  logic signed [63:0] y_r, y_nxt;
  logic signed [63:0] px_r, px_nxt;
  logic signed [63:0] py_r, py_nxt;
  logic signed [63:0] len_r, len_nxt;
  logic signed [63:0] re_r, re_nxt;
  logic signed [63:0] im_r, im_nxt;
  logic signed [63:0] t_r, t_nxt;
  logic signed [63:0] u_r, u_nxt;
  logic               sat_r, sat_nxt;
  out_req_t           out_data_r;

  // Coefficient tables.
  logic signed [63:0] skew_mem [DEPTH];
  logic signed [63:0] norm_mem [DEPTH];

  cw_t                cw;
  logic [5:0]         ord_w;
  logic [IDX_W-1:0]   n_idx;
  logic [IDX_W-1:0]   rd_idx;
  logic [IDX_W-1:0]   wr_idx;
  logic               tbl_we;
  logic signed [63:0] norm_rd;
  logic signed [63:0] skew_rd;
  logic               mul_start;
  logic signed [63:0] mul_a;
  logic signed [63:0] mul_b;
  mul_res_t           mul_res;
  logic signed [63:0] alu_a;
  logic signed [63:0] alu_b;
  logic signed [63:0] alu_y;
  logic signed [63:0] alu_sum;
  logic signed [63:0] alu_dif;
  logic               alu_sat;
  logic               go;
  logic               out_load;

  assign cw = ucode(step_r);

  // An order above TOP_ORDER evaluates the whole table.
  assign ord_w  = (6'(order_r) > 6'(TOP_ORDER)) ? 6'(TOP_ORDER) : 6'(order_r);
  assign n_idx  = IDX_W'(ord_w);
  assign rd_idx = (state_r == SEQ_IDLE || idx_r == '0) ? n_idx : idx_r - IDX_W'(1);
  assign wr_idx = IDX_W'(in_data.coef_index);

  assign norm_rd = vld_r[rd_idx] ? norm_mem[rd_idx] : '0;
  assign skew_rd = vld_r[rd_idx] ? skew_mem[rd_idx] : '0;

  // Multiplier operand selection.
  always_comb begin
    case (cw.ma)
      MA_RE:   mul_a = re_r;
      MA_IM:   mul_a = im_r;
      MA_LEN:  mul_a = len_r;
      default: mul_a = re_r;
    endcase
    case (cw.mb)
      MB_X:    mul_b = x_r;
      MB_Y:    mul_b = y_r;
      MB_RE:   mul_b = re_r;
      MB_IM:   mul_b = im_r;
      default: mul_b = x_r;
    endcase
  end

  tmk_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .res   (mul_res)
  );

  // Saturating adder. Overflow clamps to the bound on the side of the first operand.
  always_comb begin
    case (cw.aa)
      AA_T:    alu_a = t_r;
      AA_U:    alu_a = u_r;
      AA_PX:   alu_a = px_r;
      AA_PY:   alu_a = py_r;
      default: alu_a = t_r;
    endcase
    case (cw.ab)
      AB_PROD: alu_b = mul_res.prod;
      AB_NORM: alu_b = norm_rd;
      AB_SKEW: alu_b = skew_rd;
      default: alu_b = mul_res.prod;
    endcase
    alu_sum = alu_a + alu_b;
    alu_dif = alu_a - alu_b;
    case (cw.op)
      ALU_PASS: begin
        alu_y   = alu_b;
        alu_sat = 1'b0;
      end
      ALU_ADD: begin
        alu_sat = (alu_a[63] == alu_b[63]) && (alu_sum[63] != alu_a[63]);
        alu_y   = alu_sat ? (alu_a[63] ? Q_MIN : Q_MAX) : alu_sum;
      end
      ALU_SUB: begin
        alu_sat = (alu_a[63] != alu_b[63]) && (alu_dif[63] != alu_a[63]);
        alu_y   = alu_sat ? (alu_a[63] ? Q_MIN : Q_MAX) : alu_dif;
      end
      default: begin
        alu_y   = alu_b;
        alu_sat = 1'b0;
      end
    endcase
  end

  // Sequencer: next state, step, and datapath writes.
  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    idx_nxt      = idx_r;
    mul_wait_nxt = mul_wait_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    px_nxt       = px_r;
    py_nxt       = py_r;
    len_nxt      = len_r;
    re_nxt       = re_r;
    im_nxt       = im_r;
    t_nxt        = t_r;
    u_nxt        = u_r;
    sat_nxt      = sat_r;
    mul_start    = 1'b0;
    tbl_we       = 1'b0;
    out_load     = 1'b0;
    go           = 1'b0;
    in_ready     = (state_r == SEQ_IDLE);

    case (state_r)
      SEQ_IDLE: begin
        if (in_valid) begin
          if (in_data.func == FUNC_LOAD) begin
            // A load to an order beyond the table is dropped.
            tbl_we = (6'(in_data.coef_index) <= 6'(TOP_ORDER));
          end else begin
            x_nxt     = in_data.pos_x;
            y_nxt     = in_data.pos_y;
            px_nxt    = in_data.mom_x;
            py_nxt    = in_data.mom_y;
            len_nxt   = in_data.kick_len;
            re_nxt    = norm_rd;
            im_nxt    = skew_rd;
            idx_nxt   = n_idx;
            sat_nxt   = 1'b0;
            state_nxt = SEQ_RUN;
            step_nxt  = (n_idx == '0) ? STEP_KICK : STEP_LOOP;
          end
        end
      end
      SEQ_RUN: begin
        if (cw.done) begin
          if (!out_valid_r || out_ready) begin
            out_load  = 1'b1;
            state_nxt = SEQ_IDLE;
          end
        end else begin
          if (cw.use_mul) begin
            if (!mul_wait_r) begin
              mul_start    = 1'b1;
              mul_wait_nxt = 1'b1;
            end
            go = mul_wait_r && mul_res.done;
          end else begin
            go = 1'b1;
          end
          if (go) begin
            mul_wait_nxt = 1'b0;
            sat_nxt      = sat_r | alu_sat | (cw.use_mul & mul_res.sat);
            case (cw.dst)
              DST_T:   t_nxt  = alu_y;
              DST_U:   u_nxt  = alu_y;
              DST_IM:  im_nxt = alu_y;
              DST_PX:  px_nxt = alu_y;
              DST_PY:  py_nxt = alu_y;
              default: begin
              end
            endcase
            if (cw.re_load) begin
              re_nxt = t_r;
            end
            if (cw.dec_idx) begin
              idx_nxt = idx_r - IDX_W'(1);
            end
            if (cw.jmp_nz && idx_r != IDX_W'(1)) begin
              step_nxt = cw.target;
            end else begin
              step_nxt = step_r + 4'd1;
            end
          end
        end
      end
      default: begin
        state_nxt = SEQ_IDLE;
      end
    endcase

    out_valid_nxt = out_load ? 1'b1 : (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SEQ_IDLE;
      step_r      <= STEP_LOOP;
      idx_r       <= '0;
      mul_wait_r  <= 1'b0;
      out_valid_r <= 1'b0;
      order_r     <= '0;
      vld_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      idx_r       <= idx_nxt;
      mul_wait_r  <= mul_wait_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        order_r <= cfg_data;
      end
      if (tbl_we) begin
        vld_r[wr_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    px_r  <= px_nxt;
    py_r  <= py_nxt;
    len_r <= len_nxt;
    re_r  <= re_nxt;
    im_r  <= im_nxt;
    t_r   <= t_nxt;
    u_r   <= u_nxt;
    sat_r <= sat_nxt;
    if (out_load) begin
      out_data_r.mom_x_out <= px_r;
      out_data_r.mom_y_out <= py_r;
      out_data_r.saturated <= sat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      skew_mem[wr_idx] <= in_data.coef_skew;
      norm_mem[wr_idx] <= in_data.coef_normal;
    end
  end

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A product only arrives while the sequencer is waiting for one.
  a_mul_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    mul_res.done |-> mul_wait_r)
    else $error("multiplier result with no pending request");

  // An accepted kick starts the microprogram on the next cycle.
  a_kick_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.func == FUNC_KICK) |=> state_r == SEQ_RUN)
    else $error("kick request did not start the sequencer");

  // A result appears only from the final microcode step.
  a_out_from_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == SEQ_RUN && step_r == STEP_END))
    else $error("result loaded outside the final step");

  // Inside the Horner loop the iteration index never reaches zero.
  a_idx_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == SEQ_RUN && step_r < STEP_KICK) |-> idx_r != '0)
    else $error("Horner loop running with a zero index");

endmodule
